// ===== hw/rtl/imn_pkg.sv =====
package imn_pkg;

	// fixed field widths
	localparam int PIXEL_BITS    = 8;
	localparam int FRACTION_BITS = 15;
	localparam int NORM_BITS     = FRACTION_BITS + 1;
	localparam int CNT_BITS      = $clog2(FRACTION_BITS);

	// input request
	typedef struct packed {
		logic                  command;
		logic [PIXEL_BITS-1:0] pixel;
		logic                  last;
	} sample_t;

	// output request
	typedef struct packed {
		logic [NORM_BITS-1:0] normalized;
		logic                 flat_image;
		logic                 last_out;
	} result_t;

	// request commands
	localparam logic CMD_MEASURE   = 1'b0;
	localparam logic CMD_NORMALIZE = 1'b1;

	// how the back end settles one normalize request
	typedef enum logic [1:0] {
		JOB_FLAT,
		JOB_ZERO,
		JOB_ONE,
		JOB_DIV
	} job_kind_t;

	typedef struct packed {
		job_kind_t             kind;
		logic [PIXEL_BITS-1:0] num;
		logic [PIXEL_BITS-1:0] den;
		logic                  last;
	} job_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hw/rtl/image_min_max_normalizer.sv =====
// Normalize requests are queued and popped one at a time by the back end, which settles
// flat and saturating ones at once and runs the rest through the serial restoring divider,
// one quotient bit per cycle; the next is popped once the result is loaded for output.
// Measure requests are taken every cycle while the queue is not full and give no result.
// Reset (arst_n, async, low): clears tracking to min 255 / max 0, latched range to 0/0, empties
// the queue and drops any pending result.
module image_min_max_normalizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  imn_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output imn_pkg::result_t result
);
	import imn_pkg::*;

	q_stat_t q_stat;
	job_t    push_job, head;
	logic    push, pop;

	imn_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.q_stat       (q_stat),
		.push         (push),
		.job          (push_job)
	);

	imn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	imn_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== hw/rtl/imn_front.sv =====
module imn_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  imn_pkg::sample_t sample,
	input  imn_pkg::q_stat_t q_stat,
	output logic             push,
	output imn_pkg::job_t    job
);
	import imn_pkg::*;

	logic [PIXEL_BITS-1:0] running_min_q, running_max_q;
	logic [PIXEL_BITS-1:0] image_min_q, image_max_q;
	logic [PIXEL_BITS-1:0] mn, mx;
	logic                  accept;

	assign sample_stall = q_stat.full;
	assign accept       = sample_valid && !q_stat.full;
	assign push         = accept && (sample.command == CMD_NORMALIZE);

	// fold pixel into running pair
	always_comb begin
		mn = (sample.pixel < running_min_q) ? sample.pixel : running_min_q;
		mx = (sample.pixel > running_max_q) ? sample.pixel : running_max_q;
	end

	// classify a normalize request against the latched range
	always_comb begin
		job.last = sample.last;
		job.num  = sample.pixel - image_min_q;
		job.den  = image_max_q - image_min_q;
		if (image_max_q <= image_min_q) begin
			job.kind = JOB_FLAT;
		end else if (sample.pixel <= image_min_q) begin
			job.kind = JOB_ZERO;
		end else if (sample.pixel >= image_max_q) begin
			job.kind = JOB_ONE;
		end else begin
			job.kind = JOB_DIV;
		end
	end

	// measure pass tracking; last latches and restarts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_min_q <= '1;
			running_max_q <= '0;
			image_min_q   <= '0;
			image_max_q   <= '0;
		end else if (accept && sample.command == CMD_MEASURE) begin
			if (sample.last) begin
				image_min_q   <= mn;
				image_max_q   <= mx;
				running_min_q <= '1;
				running_max_q <= '0;
			end else begin
				running_min_q <= mn;
				running_max_q <= mx;
			end
		end
	end

endmodule

// ===== hw/rtl/imn_queue.sv =====
module imn_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  imn_pkg::job_t    push_job,
	input  logic             pop,
	output imn_pkg::job_t    head,
	output imn_pkg::q_stat_t q_stat
);
	import imn_pkg::*;

	localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	job_t                mem_q [DEPTH];
	logic [IDX_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("queue pop while empty");

endmodule

// ===== hw/rtl/imn_back.sv =====
module imn_back (
	input  logic             clk,
	input  logic             arst_n,
	input  imn_pkg::job_t    head,
	input  imn_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output imn_pkg::result_t result
);
	import imn_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t                 state_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [PIXEL_BITS-1:0]  rem_q, den_q;
	logic [FRACTION_BITS-1:0] quo_q;
	result_t                pend_q;
	result_t                result_q;
	logic                   result_valid_q;
	logic [PIXEL_BITS:0]    shifted, diff;
	logic                   qbit, out_free;

	assign pop          = (state_q == ST_IDLE) && !q_stat.empty;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;

	// one restoring step: shift, trial subtract
	always_comb begin
		shifted = {rem_q, 1'b0};
		diff    = shifted - {1'b0, den_q};
		qbit    = (shifted >= {1'b0, den_q});
	end

	// sequencer, divider and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			cnt_q          <= '0;
			rem_q          <= '0;
			den_q          <= '0;
			quo_q          <= '0;
			pend_q         <= '0;
			result_q       <= '0;
		end else begin
			// output valid: load from hold, drop once taken
			if ((state_q == ST_HOLD) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						pend_q.last_out <= head.last;
						case (head.kind)
							JOB_FLAT: begin
								pend_q.flat_image <= 1'b1;
								pend_q.normalized <= '0;
								state_q           <= ST_HOLD;
							end
							JOB_ZERO: begin
								pend_q.flat_image <= 1'b0;
								pend_q.normalized <= '0;
								state_q           <= ST_HOLD;
							end
							JOB_ONE: begin
								pend_q.flat_image <= 1'b0;
								pend_q.normalized <= {1'b1, {FRACTION_BITS{1'b0}}};
								state_q           <= ST_HOLD;
							end
							JOB_DIV: begin
								pend_q.flat_image <= 1'b0;
								rem_q             <= head.num;
								den_q             <= head.den;
								cnt_q             <= '0;
								state_q           <= ST_DIV;
							end
							default: begin
								pend_q.flat_image <= 1'b0;
								pend_q.normalized <= '0;
								state_q           <= ST_HOLD;
							end
						endcase
					end
				end
				ST_DIV: begin
					rem_q <= qbit ? diff[PIXEL_BITS-1:0] : shifted[PIXEL_BITS-1:0];
					quo_q <= {quo_q[FRACTION_BITS-2:0], qbit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(FRACTION_BITS - 1)) begin
						pend_q.normalized <= {1'b0, quo_q[FRACTION_BITS-2:0], qbit};
						state_q           <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						result_q <= pend_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_flat_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.flat_image) |-> (result_q.normalized == '0))
		else $error("flat result not zero");

	a_at_most_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.normalized <= {1'b1, {FRACTION_BITS{1'b0}}}))
		else $error("normalized value above one");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |=> $stable(result_q))
		else $error("output overwritten while stalled");

endmodule

// ===== tb/image_min_max_normalizer_tb.sv =====
`timescale 1ns / 1ps

module image_min_max_normalizer_tb;
	import imn_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_PCT = 37;
	localparam int ONE_Q15 = 1 << FRACTION_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sample_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	// predictor state
	logic [PIXEL_BITS-1:0] run_min;
	logic [PIXEL_BITS-1:0] run_max;
	logic [PIXEL_BITS-1:0] img_min;
	logic [PIXEL_BITS-1:0] img_max;
	result_t expected_norms[$];

	bit idle_on = 1'b1;
	int errors = 0;
	int cycles = 0;
	int measure_reqs = 0;
	int normalize_reqs = 0;
	int results_checked = 0;
	int flat_results = 0;
	int saturated_results = 0;

	image_min_max_normalizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_norms.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report(input string what);
		if (errors < 50)
			$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	// scale one pixel against the latched range, Q1.15 truncated
	function automatic result_t normalize_pixel(input logic [PIXEL_BITS-1:0] px,
		input logic last);
		result_t r;
		logic [31:0] num;
		r = '0;
		r.last_out = last;
		if (img_max <= img_min) begin
			r.flat_image = 1'b1;
		end else if (px <= img_min) begin
			r.normalized = '0;
		end else if (px >= img_max) begin
			r.normalized = NORM_BITS'(ONE_Q15);
		end else begin
			num = 32'(px - img_min) << FRACTION_BITS;
			r.normalized = NORM_BITS'(num / 32'(img_max - img_min));
		end
		return r;
	endfunction

	// update range tracking or queue the expected result for an accepted request
	task automatic apply_pixel(input sample_t s);
		logic [PIXEL_BITS-1:0] mn;
		logic [PIXEL_BITS-1:0] mx;
		if (s.command == CMD_MEASURE) begin
			measure_reqs++;
			mn = (s.pixel < run_min) ? s.pixel : run_min;
			mx = (s.pixel > run_max) ? s.pixel : run_max;
			if (s.last) begin
				img_min = mn;
				img_max = mx;
				run_min = '1;
				run_max = '0;
			end else begin
				run_min = mn;
				run_max = mx;
			end
		end else begin
			normalize_reqs++;
			expected_norms.push_back(normalize_pixel(s.pixel, s.last));
		end
	endtask

	// drive one request, hold it through stalls, then predict
	task automatic send_pixel(input logic cmd, input logic [PIXEL_BITS-1:0] px,
		input logic last);
		sample_t s;
		s = '{command: cmd, pixel: px, last: last};
		@(negedge clk);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample_valid = 1'b1;
		sample = s;
		do @(posedge clk); while (sample_stall);
		apply_pixel(s);
	endtask

	// receiver back-pressure
	always @(negedge clk)
		result_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);

	// result checker
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_norms.size() == 0) begin
				report($sformatf("unexpected result normalized=%0d flat=%0b last=%0b",
					result.normalized, result.flat_image, result.last_out));
			end else begin
				exp_r = expected_norms.pop_front();
				results_checked++;
				if (exp_r.flat_image)
					flat_results++;
				if (exp_r.normalized == 0 || exp_r.normalized == ONE_Q15)
					saturated_results++;
				if (result.normalized !== exp_r.normalized)
					report($sformatf("normalized got %0d exp %0d", result.normalized,
						exp_r.normalized));
				if (result.flat_image !== exp_r.flat_image)
					report($sformatf("flat_image got %b exp %b", result.flat_image,
						exp_r.flat_image));
				if (result.last_out !== exp_r.last_out)
					report($sformatf("last_out got %b exp %b", result.last_out,
						exp_r.last_out));
			end
		end
	end

	// normalize before any range was latched: flat
	task automatic test_before_measure();
		send_pixel(CMD_NORMALIZE, 8'd0, 1'b0);
		send_pixel(CMD_NORMALIZE, 8'd128, 1'b0);
		send_pixel(CMD_NORMALIZE, 8'd255, 1'b1);
	endtask

	// full range 0..255 and the pixel extremes
	task automatic test_full_range();
		send_pixel(CMD_MEASURE, 8'd0, 1'b0);
		send_pixel(CMD_MEASURE, 8'd255, 1'b1);
		send_pixel(CMD_NORMALIZE, 8'd0, 1'b0);
		send_pixel(CMD_NORMALIZE, 8'd1, 1'b0);
		send_pixel(CMD_NORMALIZE, 8'd128, 1'b0);
		send_pixel(CMD_NORMALIZE, 8'd254, 1'b0);
		send_pixel(CMD_NORMALIZE, 8'd255, 1'b1);
	endtask

	// flat images, also a one-pixel measure pass
	task automatic test_flat_image();
		send_pixel(CMD_MEASURE, 8'd77, 1'b0);
		send_pixel(CMD_MEASURE, 8'd77, 1'b1);
		send_pixel(CMD_NORMALIZE, 8'd76, 1'b0);
		send_pixel(CMD_NORMALIZE, 8'd77, 1'b0);
		send_pixel(CMD_NORMALIZE, 8'd78, 1'b1);
		send_pixel(CMD_MEASURE, 8'd9, 1'b1);
		send_pixel(CMD_NORMALIZE, 8'd9, 1'b1);
	endtask

	// tracking carries across unmarked measure requests; out-of-range saturation
	task automatic test_saturation();
		send_pixel(CMD_MEASURE, 8'd10, 1'b0);
		send_pixel(CMD_MEASURE, 8'd200, 1'b0);
		send_pixel(CMD_MEASURE, 8'd50, 1'b1);
		send_pixel(CMD_NORMALIZE, 8'd5, 1'b0);
		send_pixel(CMD_NORMALIZE, 8'd11, 1'b0);
		send_pixel(CMD_NORMALIZE, 8'd199, 1'b0);
		send_pixel(CMD_NORMALIZE, 8'd250, 1'b1);
	endtask

	// random two-pass images with some stray requests mixed in
	task automatic test_random_images(input int n_items);
		int sent;
		int lo;
		int hi;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) < 8) begin
				lo = $urandom_range(255);
				if ($urandom_range(3) == 0)
					hi = lo + $urandom_range(3);
				else
					hi = lo + $urandom_range(255 - lo);
				if (hi > 255)
					hi = 255;
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_pixel(CMD_MEASURE, 8'($urandom_range(lo, hi)), i == len - 1);
				sent += len;
				len = $urandom_range(1, 10);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(4) == 0)
						send_pixel(CMD_NORMALIZE, 8'($urandom_range(255)), i == len - 1);
					else
						send_pixel(CMD_NORMALIZE, 8'($urandom_range(lo, hi)), i == len - 1);
				end
				sent += len;
			end else begin
				send_pixel(1'($urandom_range(1)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	initial begin
		run_min = '1;
		run_max = '0;
		img_min = '0;
		img_max = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_before_measure();
		test_full_range();
		test_flat_image();
		test_saturation();
		test_random_images(330);
		// back-to-back stretch, no idling on either side
		idle_on = 1'b0;
		test_random_images(150);
		idle_on = 1'b1;
		test_random_images(320);

		@(negedge clk);
		sample_valid = 1'b0;
		while (expected_norms.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d measure and %0d normalize requests in %0d cycles",
			measure_reqs, normalize_reqs, cycles);
		$display("checked %0d results: %0d flat, %0d at 0 or 1.0, %0d mismatches",
			results_checked, flat_results, saturated_results, errors);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/imn_pkg.sv
hw/rtl/imn_front.sv
hw/rtl/imn_queue.sv
hw/rtl/imn_back.sv
hw/rtl/image_min_max_normalizer.sv
tb/image_min_max_normalizer_tb.sv
